[rtl/multi_pattern_match_counter_defines.svh]
// Assertion macros shared by the checker.
`ifndef MULTI_PATTERN_MATCH_COUNTER_DEFINES_SVH
`define MULTI_PATTERN_MATCH_COUNTER_DEFINES_SVH

// Consequence holds in the same cycle as the antecedent.
`define MPMC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define MPMC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mpmc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mpmc_pkg;

  // Operation codes
  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_PATTERN = 3'd1,
    OP_BUILD   = 3'd2,
    OP_TEXT    = 3'd3,
    OP_QUERY   = 3'd4
  } op_t;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NODE_FULL = 2'd1;
  localparam logic [1:0] ST_LIST_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_BUILT = 2'd3;

  // Sequencer states
  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISPATCH,
    S_LK_A, S_LK_B, S_LK_C,
    S_FO_TEST, S_FO_CHK, S_FO_FAIL,
    S_PI_CHK,
    S_BD_SYM, S_BD_GOT, S_BD_SET, S_BD_NEXT, S_BD_V, S_BD_FV,
    S_TX_CLR, S_TX_GO, S_TX_INC, S_TX_WR,
    S_PR_RD, S_PR_U, S_PR_F, S_PR_ADD,
    S_Q_A, S_Q_N, S_Q_C
  } state_t;

endpackage
`default_nettype wire

[rtl/mpmc_sat_add.sv]
`timescale 1ns / 1ps
`default_nettype none
module mpmc_sat_add #(
  parameter int W = 32
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic      [W-1:0] sum
);

  logic [W:0] raw;

  // Add and clamp at all ones
  assign raw = {1'b0, a} + {1'b0, b};
  assign sum = raw[W] ? '1 : raw[W-1:0];

endmodule
`default_nettype wire

[rtl/multi_pattern_match_counter.sv]
`timescale 1ns / 1ps
`default_nettype none
// Aho-Corasick multi-pattern occurrence counter.
// Input: a command transaction (operation, symbol, first, last, pattern_index) is taken
// on a clock edge with start high and busy low. Output: done pulses for one cycle with
// pattern_index_res, count and status in the cycle where busy drops; the receiver cannot
// stall, nothing is held back.
// One small sequencer drives memories with registered reads (child table, parent/symbol, failure
// links, breadth order, visit counts, pattern end nodes) and one saturating adder.
// A child lookup runs through S_LK_A, S_LK_B and S_LK_C; it is checked against the stored
// parent and symbol of the node, so the child table is only zeroed once after reset.
// A text byte follows failure links until a child is found or the root is reached, then
// adds one to the visit count of the node reached. A first text byte first zeroes the
// counts of every node; a last text byte then adds the count of each node below the root,
// in reverse breadth order, into the node at its failure link. Build looks up each of 256
// symbols of the root and of every node, follows failure links for each child below depth
// one and takes nodes from the breadth-first list. One transaction at a time.
// Reset empties the trie (root only), drops built links and pattern count, then holds busy
// while all NODE_SLOTS*256 entries of the child table are zeroed.
module multi_pattern_match_counter #(
  parameter int NODE_SLOTS    = 1024,
  parameter int PATTERN_SLOTS = 64,
  parameter int COUNT_BITS    = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  operation,
  input  wire logic [7:0]  symbol,
  input  wire logic        first,
  input  wire logic        last,
  input  wire logic [5:0]  pattern_index,
  output logic             done,
  output logic [5:0]       pattern_index_res,
  output logic [31:0]      count,
  output logic [1:0]       status
);
  import mpmc_pkg::*;

  localparam int NB  = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int NCW = $clog2(NODE_SLOTS + 1);
  localparam int PB  = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
  localparam int PCW = $clog2(PATTERN_SLOTS + 1);
  localparam int CW  = COUNT_BITS;

  // Memories
  logic [NB-1:0] child_mem [NODE_SLOTS*256];
  logic [NB-1:0] parent_mem [NODE_SLOTS];
  logic [7:0]    sym_mem [NODE_SLOTS];
  logic [NB-1:0] fail_mem [NODE_SLOTS];
  logic [NB-1:0] order_mem [NODE_SLOTS];
  logic [CW-1:0] vcnt_mem [NODE_SLOTS];
  logic [NB-1:0] pend_mem [PATTERN_SLOTS];

  state_t state, state_next, lk_ret, fo_ret;

  logic [2:0]     op_r;
  logic [7:0]     sym_r;
  logic           first_r, last_r;
  logic [5:0]     pidx_r;
  logic [NCW-1:0] node_count;
  logic [PCW-1:0] pattern_total;
  logic [NB-1:0]  ins_cur, match_cur;
  logic           built;

  logic [NB-1:0] lk_node, lk_u, lk_res, w, v, fv, ch_u, fu, head, tail, ci, pi;
  logic [7:0]    lk_sym, c;
  logic          root_phase;
  logic [CW-1:0] cu;

  logic [NB-1:0] ct_q, np_q, fl_q, bo_q, pe_q;
  logic [7:0]    ns_q;
  logic [CW-1:0] vc_q;

  logic              ct_we, np_we, fl_we, bo_we, vc_we, pe_we;
  logic [NB+7:0]     ct_raddr;
  logic [NB-1:0]     ct_wdata;
  logic [NB-1:0]     np_waddr, fl_raddr, fl_waddr, fl_wdata;
  logic [NB-1:0]     bo_raddr, bo_waddr, bo_wdata, vc_raddr, vc_waddr, pe_wdata;
  logic [PB-1:0]     pe_raddr, pe_waddr;
  logic [CW-1:0]     vc_wdata, add_b, add_sum;

  logic          emit;
  logic [5:0]    emit_idx;
  logic [31:0]   emit_cnt;
  logic [1:0]    emit_st;

  logic          lk_hit, node_full, list_full, bad_query, init_last;
  logic [NB-1:0] alloc_node, cur_sel, pi_dec;
  logic [31:0]   cnt_clamp;

  assign busy      = (state != S_IDLE);
  assign lk_hit    = (lk_u != '0) && (NCW'(lk_u) < node_count) &&
                     (np_q == lk_node) && (ns_q == lk_sym);
  assign node_full = (node_count >= NCW'(NODE_SLOTS));
  assign list_full = (pattern_total >= PCW'(PATTERN_SLOTS));
  assign bad_query = !built || (32'(pidx_r) >= 32'(pattern_total));
  assign alloc_node = NB'(node_count);
  assign cur_sel   = first_r ? '0 : ins_cur;
  assign pi_dec    = pi - 1'b1;
  assign cnt_clamp = (vc_q > CW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(vc_q);
  assign ct_raddr  = {lk_node, lk_sym};
  assign init_last = (ct_raddr == (NB+8)'(NODE_SLOTS*256 - 1));
  assign pe_raddr  = PB'(pidx_r);
  assign add_b     = (state == S_PR_ADD) ? cu : CW'(1);

  // Shared saturating adder
  mpmc_sat_add #(.W(CW)) u_add (.a(vc_q), .b(add_b), .sum(add_sum));

  // Memory ports, registered reads
  always_ff @(posedge clk) begin
    if (ct_we) child_mem[ct_raddr] <= ct_wdata;
    ct_q <= child_mem[ct_raddr];
  end

  always_ff @(posedge clk) begin
    if (np_we) begin
      parent_mem[np_waddr] <= lk_node;
      sym_mem[np_waddr]    <= lk_sym;
    end
    np_q <= parent_mem[ct_q];
    ns_q <= sym_mem[ct_q];
  end

  always_ff @(posedge clk) begin
    if (fl_we) fail_mem[fl_waddr] <= fl_wdata;
    fl_q <= fail_mem[fl_raddr];
  end

  always_ff @(posedge clk) begin
    if (bo_we) order_mem[bo_waddr] <= bo_wdata;
    bo_q <= order_mem[bo_raddr];
  end

  always_ff @(posedge clk) begin
    if (vc_we) vcnt_mem[vc_waddr] <= vc_wdata;
    vc_q <= vcnt_mem[vc_raddr];
  end

  always_ff @(posedge clk) begin
    if (pe_we) pend_mem[pe_waddr] <= pe_wdata;
    pe_q <= pend_mem[pe_raddr];
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  // Sequence next state and memory controls
  always_comb begin
    state_next = state;
    ct_we = 1'b0; np_we = 1'b0; fl_we = 1'b0; bo_we = 1'b0; vc_we = 1'b0; pe_we = 1'b0;
    ct_wdata = alloc_node;
    np_waddr = alloc_node;
    fl_raddr = w; fl_waddr = ch_u; fl_wdata = lk_res;
    bo_raddr = head; bo_waddr = tail; bo_wdata = lk_res;
    vc_raddr = lk_res; vc_waddr = alloc_node; vc_wdata = '0;
    pe_waddr = PB'(pattern_total); pe_wdata = alloc_node;
    emit = 1'b0; emit_idx = '0; emit_cnt = '0; emit_st = ST_OK;
    case (state)
      S_INIT: begin
        ct_we = 1'b1; ct_wdata = '0;
        if (init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (op_r)
          OP_CLEAR:   state_next = S_IDLE;
          OP_PATTERN: state_next = S_LK_A;
          OP_BUILD:   state_next = S_BD_SYM;
          OP_TEXT: begin
            if (!built) begin
              emit = 1'b1; emit_st = ST_NOT_BUILT; state_next = S_IDLE;
            end else if (first_r) state_next = S_TX_CLR;
            else state_next = S_TX_GO;
          end
          OP_QUERY: begin
            if (bad_query) begin
              emit = 1'b1; emit_idx = pidx_r; emit_st = ST_NOT_BUILT; state_next = S_IDLE;
            end else state_next = S_Q_A;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_LK_A: state_next = S_LK_B;
      S_LK_B: state_next = S_LK_C;
      S_LK_C: state_next = lk_ret;
      S_FO_TEST: state_next = S_LK_A;
      S_FO_CHK: begin
        if (lk_res != '0 || w == '0) state_next = fo_ret;
        else state_next = S_FO_FAIL;
      end
      S_FO_FAIL: state_next = S_FO_TEST;
      S_PI_CHK: begin
        state_next = S_IDLE;
        if (lk_res == '0 && node_full) begin
          emit = 1'b1; emit_st = ST_NODE_FULL;
        end else begin
          if (lk_res == '0) begin
            ct_we = 1'b1; np_we = 1'b1; vc_we = 1'b1;
          end else pe_wdata = lk_res;
          if (last_r) begin
            emit = 1'b1;
            if (list_full) emit_st = ST_LIST_FULL;
            else begin
              pe_we = 1'b1; emit_idx = 6'(pattern_total);
            end
          end
        end
      end
      S_BD_SYM: state_next = S_LK_A;
      S_BD_GOT: begin
        if (lk_res == '0) state_next = S_BD_NEXT;
        else begin
          bo_we = 1'b1;
          if (root_phase) begin
            fl_we = 1'b1; fl_waddr = lk_res; fl_wdata = '0; state_next = S_BD_NEXT;
          end else state_next = S_FO_TEST;
        end
      end
      S_BD_SET: begin
        fl_we = 1'b1; state_next = S_BD_NEXT;
      end
      S_BD_NEXT: begin
        if (c != 8'hFF) state_next = S_BD_SYM;
        else if (head == tail) begin
          emit = 1'b1; state_next = S_IDLE;
        end else state_next = S_BD_V;
      end
      S_BD_V: begin
        fl_raddr = bo_q; state_next = S_BD_FV;
      end
      S_BD_FV: state_next = S_BD_SYM;
      S_TX_CLR: begin
        vc_we = 1'b1; vc_waddr = ci;
        if (ci == NB'(node_count - 1'b1)) state_next = S_TX_GO;
      end
      S_TX_GO: state_next = S_FO_TEST;
      S_TX_INC: state_next = S_TX_WR;
      S_TX_WR: begin
        vc_we = 1'b1; vc_waddr = match_cur; vc_wdata = add_sum;
        state_next = last_r ? S_PR_RD : S_IDLE;
      end
      S_PR_RD: begin
        bo_raddr = pi_dec;
        state_next = (pi == '0) ? S_IDLE : S_PR_U;
      end
      S_PR_U: begin
        fl_raddr = bo_q; vc_raddr = bo_q; state_next = S_PR_F;
      end
      S_PR_F: begin
        vc_raddr = fl_q; state_next = S_PR_ADD;
      end
      S_PR_ADD: begin
        vc_we = 1'b1; vc_waddr = fu; vc_wdata = add_sum; state_next = S_PR_RD;
      end
      S_Q_A: state_next = S_Q_N;
      S_Q_N: begin
        vc_raddr = pe_q; state_next = S_Q_C;
      end
      S_Q_C: begin
        emit = 1'b1; emit_idx = pidx_r; emit_cnt = cnt_clamp; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NCW'(1); pattern_total <= '0;
      ins_cur <= '0; match_cur <= '0; built <= 1'b0; done <= 1'b0;
      lk_node <= '0; lk_sym <= '0;
    end else begin
      done <= emit;
      if (emit) begin
        pattern_index_res <= emit_idx; count <= emit_cnt; status <= emit_st;
      end
      case (state)
        S_INIT: {lk_node, lk_sym} <= ct_raddr + 1'b1;
        S_IDLE: begin
          if (start) begin
            op_r <= operation; sym_r <= symbol; first_r <= first;
            last_r <= last; pidx_r <= pattern_index;
          end
        end
        S_DISPATCH: begin
          case (op_r)
            OP_CLEAR: begin
              node_count <= NCW'(1); pattern_total <= '0;
              ins_cur <= '0; match_cur <= '0; built <= 1'b0;
            end
            OP_PATTERN: begin
              lk_node <= cur_sel; lk_sym <= sym_r; lk_ret <= S_PI_CHK;
            end
            OP_BUILD: begin
              tail <= '0; head <= '0; v <= '0; root_phase <= 1'b1; c <= '0;
            end
            OP_TEXT: begin
              c <= sym_r; ci <= '0;
            end
            default: ;
          endcase
        end
        S_LK_B: lk_u <= ct_q;
        S_LK_C: lk_res <= lk_hit ? lk_u : '0;
        S_FO_TEST: begin
          lk_node <= w; lk_sym <= c; lk_ret <= S_FO_CHK;
        end
        S_FO_FAIL: w <= fl_q;
        S_PI_CHK: begin
          if (lk_res != '0 || !node_full) begin
            built <= 1'b0;
            if (lk_res != '0) ins_cur <= lk_res;
            else begin
              ins_cur <= alloc_node; node_count <= node_count + 1'b1;
            end
            if (last_r && !list_full) pattern_total <= pattern_total + 1'b1;
          end
        end
        S_BD_SYM: begin
          lk_node <= v; lk_sym <= c; lk_ret <= S_BD_GOT;
        end
        S_BD_GOT: begin
          if (lk_res != '0) begin
            tail <= tail + 1'b1; ch_u <= lk_res; w <= fv; fo_ret <= S_BD_SET;
          end
        end
        S_BD_NEXT: begin
          if (c != 8'hFF) c <= c + 1'b1;
          else if (head == tail) built <= 1'b1;
        end
        S_BD_V: begin
          v <= bo_q; head <= head + 1'b1;
        end
        S_BD_FV: begin
          fv <= fl_q; c <= '0; root_phase <= 1'b0;
        end
        S_TX_CLR: begin
          if (ci == NB'(node_count - 1'b1)) match_cur <= '0;
          else ci <= ci + 1'b1;
        end
        S_TX_GO: begin
          w <= match_cur; fo_ret <= S_TX_INC;
        end
        S_TX_INC: match_cur <= lk_res;
        S_TX_WR: pi <= NB'(node_count - 1'b1);
        S_PR_F: begin
          fu <= fl_q; cu <= vc_q;
        end
        S_PR_ADD: pi <= pi_dec;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/mpmc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "multi_pattern_match_counter_defines.svh"
module mpmc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [5:0]  pattern_index_res,
  input wire logic [31:0] count,
  input wire logic [1:0]  status
);
  import mpmc_pkg::*;

  // Accepted transaction keeps the block busy next cycle
  `MPMC_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "accept did not raise busy")
  // Results come out only when the sequencer is back at rest
  `MPMC_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "result while busy")
  // At most one result per transaction, never two in a row
  `MPMC_ASSERT_NXT(a_done_single, clk, rst, done, !done, "result repeated")
  // Only a good query carries a count
  `MPMC_ASSERT_IMP(a_count_ok, clk, rst, done && count != 32'd0, status == ST_OK, "count on error")
  // Node store full reports no index
  `MPMC_ASSERT_IMP(a_full_idx, clk, rst, done && status == ST_NODE_FULL,
    pattern_index_res == 6'd0, "index on node full")

endmodule

bind multi_pattern_match_counter mpmc_checker u_mpmc_checker (.*);
`default_nettype wire
